### hw/rtl/gwm_pkg.sv
// ----------------------------------------------------------------------------
// gwm_pkg
// Shared types, constants and helpers of the wildcard matcher.
// ----------------------------------------------------------------------------
package gwm_pkg;

  localparam int PATTERN_MAX_DEF = 32;
  localparam int CHAR_W          = 8;
  localparam int WORD_W          = 64;
  localparam int NUM_WORDS       = 4;
  localparam int BYTES_PER_WORD  = WORD_W / CHAR_W;
  localparam int LEN_W           = 6;
  localparam int CFG_IDX_W       = 3;

  localparam logic [CHAR_W-1:0] STAR_BYTE  = 8'h2A;
  localparam logic [CHAR_W-1:0] QMARK_BYTE = 8'h3F;
  localparam logic [CHAR_W-1:0] UPPER_A    = 8'h41;
  localparam logic [CHAR_W-1:0] UPPER_Z    = 8'h5A;
  localparam logic [CHAR_W-1:0] CASE_DELTA = 8'h20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CASE_FOLD      = 3'd5;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [WORD_W-1:0] word_t;

  // ASCII A-Z to lower case when enabled
  function automatic char_t fold_char(char_t c, logic en);
    char_t r;
    r = c;
    if (en && c >= UPPER_A && c <= UPPER_Z) begin
      r = c + CASE_DELTA;
    end
    return r;
  endfunction

endpackage

### hw/rtl/gwm_if.sv
// ----------------------------------------------------------------------------
// gwm_if
// Channel interfaces: subject input, match result, configuration writes.
// ----------------------------------------------------------------------------
interface gwm_in_if;
  import gwm_pkg::*;
  logic  valid;
  logic  ready;
  char_t subject_char;
  logic  last_char;
  logic  empty_subject;

  modport source (output valid, subject_char, last_char, empty_subject, input ready);
  modport sink   (input valid, subject_char, last_char, empty_subject, output ready);
endinterface

interface gwm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, matched, input ready);
  modport sink   (input valid, matched, output ready);
endinterface

interface gwm_cfg_if;
  import gwm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  word_t                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/gwm_closure.sv
// ----------------------------------------------------------------------------
// gwm_closure
// Star closure of a live-position vector: a live position on a '*' makes the
// next position live, transitively. Parallel-prefix network, log2(W) levels.
// ----------------------------------------------------------------------------
module gwm_closure #(
  parameter int W = 33
) (
  input  logic [W-1:0] live,
  input  logic [W-1:0] pass,   // pass[j]: position j-1 is a '*' in use
  output logic [W-1:0] closed
);
  localparam int LEVELS = $clog2(W);

  logic [W-1:0] g_lvl [0:LEVELS];
  logic [W-1:0] p_lvl [0:LEVELS];

  assign g_lvl[0] = live;
  assign p_lvl[0] = pass;

  for (genvar k = 0; k < LEVELS; k++) begin : g_level
    localparam int D = 1 << k;
    for (genvar j = 0; j < W; j++) begin : g_bit
      if (j >= D) begin : g_comb
        assign g_lvl[k+1][j] = g_lvl[k][j] | (p_lvl[k][j] & g_lvl[k][j-D]);
        assign p_lvl[k+1][j] = p_lvl[k][j] & p_lvl[k][j-D];
      end else begin : g_keep
        assign g_lvl[k+1][j] = g_lvl[k][j];
        assign p_lvl[k+1][j] = p_lvl[k][j];
      end
    end
  end

  assign closed = g_lvl[LEVELS];

endmodule

### hw/rtl/glob_wildcard_matcher_unit.sv
// ----------------------------------------------------------------------------
// glob_wildcard_matcher_unit
// Wildcard ('*', '?') matcher over a streamed subject, pattern in registers.
// ----------------------------------------------------------------------------
// Takes one subject byte per cycle; a closing byte waits in the input register while an
// earlier result has not been taken. An accepted transaction sits in an input register;
// once it fires, the live pattern-position vector is closed over '*', stepped by the byte
// and closed again in one pass, which sets the one-cycle rate. A transaction with
// last_char or empty_subject set loads the result register when it fires, so matched is
// registered behind the input register. The output register lets a new byte enter while
// a result waits to be taken. Configuration writes are accepted every cycle and should
// only be made while idle.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher_unit #(
  parameter int PATTERN_MAX = gwm_pkg::PATTERN_MAX_DEF
) (
  input logic       clk,
  input logic       rst,
  gwm_in_if.sink    subject,
  gwm_out_if.source result,
  gwm_cfg_if.sink   cfg
);
  import gwm_pkg::*;

  localparam int PW    = PATTERN_MAX + 1;
  localparam int IDX_W = $clog2(PW);
  localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(PATTERN_MAX);

  // configuration
  word_t             pattern_words [0:NUM_WORDS-1];
  logic [LEN_W-1:0]  pattern_length;
  logic              case_fold;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < NUM_WORDS; w++) begin
        pattern_words[w] <= '0;
      end
      pattern_length <= '0;
      case_fold      <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        REG_PATTERN_WORD_0: pattern_words[0] <= cfg.data;
        REG_PATTERN_WORD_1: pattern_words[1] <= cfg.data;
        REG_PATTERN_WORD_2: pattern_words[2] <= cfg.data;
        REG_PATTERN_WORD_3: pattern_words[3] <= cfg.data;
        REG_PATTERN_LENGTH: pattern_length   <= cfg.data[LEN_W-1:0];
        REG_CASE_FOLD:      case_fold        <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // input register
  logic  in_valid;
  char_t in_char;
  logic  in_last;
  logic  in_empty;
  logic  fire;

  assign subject.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (subject.ready) begin
      in_valid <= subject.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (subject.valid && subject.ready) begin
      in_char  <= subject.subject_char;
      in_last  <= subject.last_char;
      in_empty <= subject.empty_subject;
    end
  end

  // pattern decode
  char_t            pat_bytes [0:PATTERN_MAX-1];
  logic [LEN_W-1:0] len_eff;
  logic [IDX_W-1:0] len_idx;
  logic [PW-1:0]    live_mask;
  logic [PW-1:0]    pass;
  logic [PATTERN_MAX-1:0] star;
  logic [PATTERN_MAX-1:0] hit;
  char_t            char_folded;

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_pat
    assign pat_bytes[g] =
      pattern_words[g / BYTES_PER_WORD][(g % BYTES_PER_WORD)*CHAR_W +: CHAR_W];
  end

  assign len_eff     = (pattern_length > LEN_CAP) ? LEN_CAP : pattern_length;
  assign len_idx     = len_eff[IDX_W-1:0];
  assign char_folded = fold_char(in_char, case_fold);

  always_comb begin
    live_mask = '0;
    pass      = '0;
    star      = '0;
    hit       = '0;
    for (int j = 0; j < PW; j++) begin
      live_mask[j] = (LEN_W'(j) <= len_eff);
    end
    for (int i = 0; i < PATTERN_MAX; i++) begin
      star[i] = (LEN_W'(i) < len_eff) && (pat_bytes[i] == STAR_BYTE);
      hit[i]  = (LEN_W'(i) < len_eff) && (pat_bytes[i] != STAR_BYTE) &&
                ((pat_bytes[i] == QMARK_BYTE) ||
                 (fold_char(pat_bytes[i], case_fold) == char_folded));
      pass[i+1] = star[i];
    end
  end

  // live-position update
  logic [PW-1:0] active_positions;
  logic [PW-1:0] active_positions_next;
  logic [PW-1:0] cur_seed;
  logic [PW-1:0] cur_pre;
  logic [PW-1:0] cur_closed;
  logic [PW-1:0] nxt_raw;
  logic [PW-1:0] nxt_pre;
  logic [PW-1:0] nxt_closed;
  logic          gives_result;
  logic          match_bit;

  // an empty subject starts over from position zero
  assign cur_seed = in_empty ? PW'(1) : (active_positions & live_mask);

  gwm_closure #(.W(PW)) u_cur_closure (
    .live   (cur_seed),
    .pass   (pass),
    .closed (cur_pre)
  );

  assign cur_closed = cur_pre & live_mask;

  always_comb begin
    nxt_raw = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      nxt_raw[i]   = nxt_raw[i] | (cur_closed[i] & star[i]);
      nxt_raw[i+1] = cur_closed[i] & hit[i];
    end
  end

  gwm_closure #(.W(PW)) u_nxt_closure (
    .live   (nxt_raw),
    .pass   (pass),
    .closed (nxt_pre)
  );

  assign nxt_closed   = nxt_pre & live_mask;
  assign gives_result = in_empty || in_last;
  assign match_bit    = in_empty ? cur_closed[len_idx] : nxt_closed[len_idx];

  assign fire = in_valid && (!gives_result || !result.valid || result.ready);
  assign active_positions_next = gives_result ? PW'(1) : nxt_closed;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_positions <= PW'(1);
    end else if (fire) begin
      active_positions <= active_positions_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (fire && gives_result) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && gives_result) begin
      result.matched <= match_bit;
    end
  end

  // checks
  a_restart_after_result: assert property (@(posedge clk) disable iff (rst)
    fire && gives_result |=> active_positions == PW'(1))
    else $error("live positions not restarted after a result");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    fire && gives_result |-> !result.valid || result.ready)
    else $error("pending result overwritten");

  a_stalled_item_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |=> in_valid && $stable(in_char) && $stable(in_last)
                          && $stable(in_empty))
    else $error("stalled input transaction lost");

endmodule
